/* hdl/ofts_pkg.sv */
package ofts_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_ALPHA   = 3'd0;
    localparam logic [2:0] CFG_THETA   = 3'd1;
    localparam logic [2:0] CFG_LAMBDA  = 3'd2;
    localparam logic [2:0] CFG_ZERO    = 3'd3;
    localparam logic [2:0] CFG_OCCL    = 3'd4;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // pipelined divider geometry: 64-bit numerators, 33-bit divisors,
    // quotient clamped to 34 bits (anything larger saturates the result)
    localparam int NUM_W    = 64;
    localparam int DIVR_W   = 33;
    localparam int QUO_BITS = 34;

    typedef struct packed {
        logic        busy;
        logic [31:0] lt;        // lambda*theta
        logic [31:0] ltd;       // 2*lt/(1+alpha*theta)
        logic [31:0] atd;       // alpha*theta/(1+alpha*theta)
        logic [32:0] opat;      // 1+alpha*theta
        logic [15:0] zero_thr;
        logic [16:0] occ_thr;
    } ofts_cfg_t;

endpackage

/* hdl/ofts_div.sv */
module ofts_div
    import ofts_pkg::*;
(
    input  logic                aclk,
    input  logic                en,
    input  logic [DIVR_W-1:0]   rem_i,
    input  logic [QUO_BITS-1:0] low_i,
    input  logic [DIVR_W-1:0]   den_i,
    output logic [QUO_BITS-1:0] quo_o
);

    // one quotient bit per stage, restoring
    logic [DIVR_W-1:0]   rem_reg [QUO_BITS-1];
    logic [QUO_BITS-1:0] low_reg [QUO_BITS-1];
    logic [DIVR_W-1:0]   den_reg [QUO_BITS-1];
    logic [QUO_BITS-1:0] quo_reg [QUO_BITS];

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        logic [DIVR_W-1:0]   rem_p;
        logic [DIVR_W-1:0]   den_p;
        logic [QUO_BITS-1:0] low_p;
        logic [QUO_BITS-1:0] quo_p;
        logic [DIVR_W:0]     trial;
        logic                ge;

        if (k == 0) begin : g_first
            assign rem_p = rem_i;
            assign den_p = den_i;
            assign low_p = low_i;
            assign quo_p = '0;
        end else begin : g_next
            assign rem_p = rem_reg[k-1];
            assign den_p = den_reg[k-1];
            assign low_p = low_reg[k-1];
            assign quo_p = quo_reg[k-1];
        end

        assign trial = {rem_p, low_p[QUO_BITS-1]};
        assign ge    = trial >= {1'b0, den_p};

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k] <= {quo_p[QUO_BITS-2:0], ge};
            end
        end

        if (k < QUO_BITS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? DIVR_W'(trial - {1'b0, den_p}) : trial[DIVR_W-1:0];
                    low_reg[k] <= low_p << 1;
                    den_reg[k] <= den_p;
                end
            end
        end
    end

    assign quo_o = quo_reg[QUO_BITS-1];

endmodule

/* hdl/ofts_cfg.sv */
module ofts_cfg
    import ofts_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_DAT_W-1:0] cfg_wr_data,
    output ofts_cfg_t            cfg_o
);

    localparam int F = FRAC_BITS;

    typedef enum logic [2:0] {ST_PROD, ST_OPAT, ST_ATD, ST_LTD, ST_DONE} state_t;

    state_t      state_reg;
    logic [31:0] alpha_reg, theta_reg, lambda_reg;
    logic [15:0] zthr_reg;
    logic [16:0] othr_reg;
    logic [31:0] lt_reg, at_reg, atd_reg, ltd_reg;
    logic [32:0] opat_reg;
    logic [63:0] num_reg;
    logic [32:0] rem_reg;
    logic [5:0]  cnt_reg;

    logic [63:0] prod_lt, prod_at;
    logic [64:0] rnd_lt, rnd_at;
    logic [31:0] lt_sat, at_sat;
    logic [32:0] opat_c;
    logic [63:0] atd_num, ltd_num;
    logic [33:0] trial;
    logic        ge;
    logic [32:0] rem_next;
    logic [63:0] num_next;

    always_comb begin
        prod_lt  = 64'(lambda_reg) * 64'(theta_reg);
        prod_at  = 64'(alpha_reg) * 64'(theta_reg);
        rnd_lt   = (65'(prod_lt) + (65'(1) << (F - 1))) >> F;
        rnd_at   = (65'(prod_at) + (65'(1) << (F - 1))) >> F;
        lt_sat   = (|rnd_lt[64:32]) ? '1 : rnd_lt[31:0];
        at_sat   = (|rnd_at[64:32]) ? '1 : rnd_at[31:0];
        opat_c   = 33'(at_reg) + (33'(1) << F);
        atd_num  = (64'(at_reg) << F) + 64'(opat_c >> 1);
        ltd_num  = (64'({lt_reg, 1'b0}) << F) + 64'(opat_reg >> 1);
        trial    = {rem_reg, num_reg[63]};
        ge       = trial >= {1'b0, opat_reg};
        rem_next = ge ? 33'(trial - {1'b0, opat_reg}) : trial[32:0];
        num_next = {num_reg[62:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= 32'd655;
            theta_reg  <= 32'd19661;
            lambda_reg <= 32'd9830;
            zthr_reg   <= 16'd1;
            othr_reg   <= 17'd32768;
            state_reg  <= ST_PROD;
        end else begin
            unique case (state_reg)
                ST_PROD: begin
                    lt_reg    <= lt_sat;
                    at_reg    <= at_sat;
                    state_reg <= ST_OPAT;
                end
                ST_OPAT: begin
                    opat_reg  <= opat_c;
                    num_reg   <= atd_num;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_ATD;
                end
                ST_ATD: begin
                    rem_reg <= rem_next;
                    num_reg <= num_next;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == '1) begin
                        atd_reg   <= num_next[31:0];
                        num_reg   <= ltd_num;
                        rem_reg   <= '0;
                        state_reg <= ST_LTD;
                    end
                end
                ST_LTD: begin
                    rem_reg <= rem_next;
                    num_reg <= num_next;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == '1) begin
                        ltd_reg   <= (|num_next[63:32]) ? '1 : num_next[31:0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                end
                default: state_reg <= ST_PROD;
            endcase

            // any write restarts the derivation
            if (cfg_wr_en) begin
                state_reg <= ST_PROD;
                unique case (cfg_wr_index)
                    CFG_ALPHA:  alpha_reg  <= cfg_wr_data;
                    CFG_THETA:  theta_reg  <= cfg_wr_data;
                    CFG_LAMBDA: lambda_reg <= cfg_wr_data;
                    CFG_ZERO:   zthr_reg   <= cfg_wr_data[15:0];
                    CFG_OCCL:   othr_reg   <= cfg_wr_data[16:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign cfg_o.busy     = state_reg != ST_DONE;
    assign cfg_o.lt       = lt_reg;
    assign cfg_o.ltd      = ltd_reg;
    assign cfg_o.atd      = atd_reg;
    assign cfg_o.opat     = opat_reg;
    assign cfg_o.zero_thr = zthr_reg;
    assign cfg_o.occ_thr  = othr_reg;

endmodule

/* hdl/occlusion_flow_threshold_step_core.sv */
// Throughput: one pixel per clock while s_tready is high; 9 arithmetic stages,
//   34 divider stages (one quotient bit each), one combine stage, then an output
//   register + skid.
// Reset (aresetn low, synchronous): pipeline emptied, registers at defaults;
//   s_tready stays low after reset or any config write while the derived
//   gains are worked out by the serial divider in ofts_cfg.
module occlusion_flow_threshold_step_core
    import ofts_pkg::*;
#(
    parameter int PIXEL_BITS = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_DAT_W-1:0] cfg_wr_data,
    // pixel input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // flow_x, flow_y, occlusion_weight, fwd_grad_x, fwd_grad_y, bck_grad_x,
    // bck_grad_y, fwd_residual_const, bck_residual_const, fwd_grad_norm_sq,
    // bck_grad_norm_sq, zero pad
    input  logic [335:0]         s_tdata,
    input  logic                 s_tlast,   // last_pixel
    // result output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_flow_x, out_flow_y, fwd_cand_x, fwd_cand_y, bck_cand_x, bck_cand_y
    output logic [191:0]         m_tdata,
    output logic                 m_tlast    // frame_end
);

    localparam int F   = FRAC_BITS;
    localparam int OB  = (PIXEL_BITS < 32) ? PIXEL_BITS : 32;
    localparam int PW  = 66;                 // wide signed working width
    localparam int QB  = QUO_BITS;
    localparam int NST = 10 + QB;            // stages carrying a valid bit

    // ---------------------------------------------------------------
    // fixed-point helpers
    // ---------------------------------------------------------------
    function automatic logic signed [PW-1:0] sx(input logic [31:0] a);
        return PW'($signed(a));
    endfunction

    function automatic logic signed [PW-1:0] zx(input logic [31:0] a);
        return $signed(PW'(a));
    endfunction

    // round to nearest, ties away from zero, drop F fraction bits
    function automatic logic signed [PW-1:0] srnd(input logic signed [PW-1:0] x);
        logic [PW-1:0] mag;
        logic [PW-1:0] r;
        mag = x[PW-1] ? PW'(-x) : PW'(x);
        r   = (mag + (PW'(1) << (F - 1))) >> F;
        return x[PW-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [PW-1:0] sat(input logic signed [PW-1:0] x,
                                                 input int w);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = $signed((PW'(1) << (w - 1)) - PW'(1));
        lo = -hi - 1;
        return (x > hi) ? hi : ((x < lo) ? lo : x);
    endfunction

    function automatic logic [PW-1:0] smag(input logic signed [PW-1:0] x);
        return x[PW-1] ? PW'(-x) : PW'(x);
    endfunction

    // per-pixel state that rides along the pipe
    typedef struct packed {
        logic signed [31:0]   ux;
        logic signed [31:0]   uy;
        logic signed [31:0]   gx;
        logic signed [31:0]   gy;
        logic signed [31:0]   bx;
        logic signed [31:0]   by;
        logic signed [31:0]   r1c;
        logic signed [31:0]   r3c;
        logic [30:0]          g1;
        logic [30:0]          g3;
        logic [16:0]          chi;
        logic                 last;
        logic signed [PW-1:0] dl1x;
        logic signed [PW-1:0] dl1y;
        logic signed [PW-1:0] dl3x;
        logic signed [PW-1:0] dl3y;
        logic signed [PW-1:0] thr1;
        logic signed [PW-1:0] thr3;
        logic signed [31:0]   rho1;
        logic signed [31:0]   rho3;
        logic                 lo1;
        logic                 hi1;
        logic                 z1;
        logic                 lo3;
        logic                 hi3;
        logic                 z3;
        logic [5:0]           neg;
        logic [5:0]           ovf;
    } car_t;

    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] kx;
        logic [31:0] ky;
        logic        last;
    } res_t;

    ofts_cfg_t cfg;

    ofts_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg_o        (cfg)
    );

    // ---------------------------------------------------------------
    // flow control: whole pipe moves unless the skid slot is occupied
    // ---------------------------------------------------------------
    logic adv;
    logic take;
    logic [NST-1:0] vpipe_reg;
    logic out_v_reg, skid_v_reg;
    res_t p_reg, out_reg, skid_reg;

    assign adv      = !skid_v_reg;
    assign s_tready = adv && !cfg.busy;
    assign take     = s_tvalid && s_tready;

    car_t in_car;
    always_comb begin
        in_car      = '0;
        in_car.ux   = s_tdata[31:0];
        in_car.uy   = s_tdata[63:32];
        in_car.chi  = s_tdata[80:64];
        in_car.gx   = s_tdata[112:81];
        in_car.gy   = s_tdata[144:113];
        in_car.bx   = s_tdata[176:145];
        in_car.by   = s_tdata[208:177];
        in_car.r1c  = s_tdata[240:209];
        in_car.r3c  = s_tdata[272:241];
        in_car.g1   = s_tdata[303:273];
        in_car.g3   = s_tdata[334:304];
        in_car.last = s_tlast;
    end

    // ---------------------------------------------------------------
    // arithmetic stages 0..8
    // ---------------------------------------------------------------
    car_t car_reg [9];

    logic signed [PW-1:0] pgxux_reg, pgyuy_reg, pbxux_reg, pbyuy_reg;
    logic signed [PW-1:0] pltgx_reg, pltgy_reg, pltdbx_reg, pltdby_reg;
    logic [PW-1:0]        pthr1_reg, pthr3_reg;
    logic signed [PW-1:0] a1_reg, a2_reg, b1_reg, b2_reg;
    logic signed [PW-1:0] s1_reg, s3_reg;
    logic signed [31:0]   s3s_reg;
    logic signed [PW-1:0] pat_reg;
    logic signed [PW-1:0] pn_reg [4];
    logic signed [PW-1:0] avp_reg;
    logic signed [31:0]   av_reg;
    logic [NUM_W-1:0]     num6_reg [6];
    logic [NUM_W-1:0]     num7_reg [6];
    logic [NUM_W-1:0]     num8_reg [6];
    logic [DIVR_W-1:0]    dv6_reg [6];
    logic [DIVR_W-1:0]    dv7_reg [6];
    logic [DIVR_W-1:0]    dv8_reg [6];

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 0: capture
            car_reg[0] <= in_car;

            // stage 1: products
            car_reg[1] <= car_reg[0];
            pgxux_reg  <= sx(car_reg[0].gx) * sx(car_reg[0].ux);
            pgyuy_reg  <= sx(car_reg[0].gy) * sx(car_reg[0].uy);
            pbxux_reg  <= sx(car_reg[0].bx) * sx(car_reg[0].ux);
            pbyuy_reg  <= sx(car_reg[0].by) * sx(car_reg[0].uy);
            pltgx_reg  <= zx(cfg.lt) * sx(car_reg[0].gx);
            pltgy_reg  <= zx(cfg.lt) * sx(car_reg[0].gy);
            pltdbx_reg <= zx(cfg.ltd) * sx(car_reg[0].bx);
            pltdby_reg <= zx(cfg.ltd) * sx(car_reg[0].by);
            pthr1_reg  <= PW'(cfg.lt) * PW'(car_reg[0].g1);
            pthr3_reg  <= PW'(cfg.ltd) * PW'(car_reg[0].g3);

            // stage 2: rounding
            car_reg[2]      <= car_reg[1];
            car_reg[2].dl1x <= srnd(pltgx_reg);
            car_reg[2].dl1y <= srnd(pltgy_reg);
            car_reg[2].dl3x <= srnd(pltdbx_reg);
            car_reg[2].dl3y <= srnd(pltdby_reg);
            car_reg[2].thr1 <= $signed((pthr1_reg + (PW'(1) << (F - 1))) >> F);
            car_reg[2].thr3 <= $signed((pthr3_reg + (PW'(1) << (F - 1))) >> F);
            a1_reg          <= srnd(pgxux_reg);
            a2_reg          <= srnd(pgyuy_reg);
            b1_reg          <= srnd(pbxux_reg);
            b2_reg          <= srnd(pbyuy_reg);

            // stage 3: gradient dot flow
            car_reg[3] <= car_reg[2];
            s1_reg     <= a1_reg + a2_reg;
            s3_reg     <= b1_reg + b2_reg;

            // stage 4: residuals
            car_reg[4]      <= car_reg[3];
            car_reg[4].rho1 <= 32'(sat(sx(car_reg[3].r1c) + s1_reg, 32));
            car_reg[4].rho3 <= 32'(sat(sx(car_reg[3].r3c) - s3_reg, 32));
            s3s_reg         <= 32'(sat(s3_reg, 32));

            // stage 5: forward branch, residual times gradient
            car_reg[5]     <= car_reg[4];
            pat_reg        <= zx(cfg.atd) * sx(s3s_reg);
            pn_reg[0]      <= sx(car_reg[4].rho1) * sx(car_reg[4].gx);
            pn_reg[1]      <= sx(car_reg[4].rho1) * sx(car_reg[4].gy);
            pn_reg[2]      <= sx(car_reg[4].rho3) * sx(car_reg[4].bx);
            pn_reg[3]      <= sx(car_reg[4].rho3) * sx(car_reg[4].by);
            car_reg[5].lo1 <= sx(car_reg[4].rho1) < -car_reg[4].thr1;
            car_reg[5].hi1 <= sx(car_reg[4].rho1) > car_reg[4].thr1;
            car_reg[5].z1  <= (car_reg[4].g1 < 31'(cfg.zero_thr)) || (car_reg[4].g1 == '0);
            car_reg[5].z3  <= (car_reg[4].g3 < 31'(cfg.zero_thr)) || (car_reg[4].g3 == '0);

            // stage 6: rounded numerator magnitudes
            car_reg[6] <= car_reg[5];
            avp_reg    <= srnd(pat_reg);
            for (int i = 0; i < 4; i++) begin
                car_reg[6].neg[i] <= pn_reg[i][PW-1];
            end
            num6_reg[0] <= NUM_W'(smag(pn_reg[0])) + NUM_W'(car_reg[5].g1 >> 1);
            num6_reg[1] <= NUM_W'(smag(pn_reg[1])) + NUM_W'(car_reg[5].g1 >> 1);
            num6_reg[2] <= NUM_W'(smag(pn_reg[2])) + NUM_W'(car_reg[5].g3 >> 1);
            num6_reg[3] <= NUM_W'(smag(pn_reg[3])) + NUM_W'(car_reg[5].g3 >> 1);
            num6_reg[4] <= (NUM_W'(smag(sx(car_reg[5].ux))) << F) + NUM_W'(cfg.opat >> 1);
            num6_reg[5] <= (NUM_W'(smag(sx(car_reg[5].uy))) << F) + NUM_W'(cfg.opat >> 1);
            car_reg[6].neg[4] <= car_reg[5].ux[31];
            car_reg[6].neg[5] <= car_reg[5].uy[31];
            dv6_reg[0] <= DIVR_W'(car_reg[5].g1);
            dv6_reg[1] <= DIVR_W'(car_reg[5].g1);
            dv6_reg[2] <= DIVR_W'(car_reg[5].g3);
            dv6_reg[3] <= DIVR_W'(car_reg[5].g3);
            dv6_reg[4] <= cfg.opat;
            dv6_reg[5] <= cfg.opat;

            // stage 7: backward test value, quotient range check
            car_reg[7] <= car_reg[6];
            av_reg     <= 32'(sat(sx(car_reg[6].rho3) + avp_reg, 32));
            for (int i = 0; i < 6; i++) begin
                car_reg[7].ovf[i] <= (NUM_W + 3)'(num6_reg[i]) >=
                                     ((NUM_W + 3)'(dv6_reg[i]) << QB);
                num7_reg[i] <= num6_reg[i];
                dv7_reg[i]  <= dv6_reg[i];
            end

            // stage 8: backward branch, divider feed
            car_reg[8]     <= car_reg[7];
            car_reg[8].lo3 <= sx(av_reg) < -car_reg[7].thr3;
            car_reg[8].hi3 <= sx(av_reg) > car_reg[7].thr3;
            for (int i = 0; i < 6; i++) begin
                num8_reg[i] <= num7_reg[i];
                dv8_reg[i]  <= dv7_reg[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // six dividers in lock-step, side data alongside
    // ---------------------------------------------------------------
    logic [QB-1:0] quo [6];

    for (genvar i = 0; i < 6; i++) begin : g_div
        ofts_div u_div (
            .aclk  (aclk),
            .en    (adv),
            .rem_i (DIVR_W'(num8_reg[i][NUM_W-1:QB])),
            .low_i (num8_reg[i][QB-1:0]),
            .den_i (dv8_reg[i]),
            .quo_o (quo[i])
        );
    end

    car_t side_reg [QB];

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= car_reg[8];
            for (int k = 1; k < QB; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // combine: pick branch per candidate, saturate, occlusion select
    // ---------------------------------------------------------------
    car_t                 sd;
    logic signed [PW-1:0] qs [6];
    logic signed [PW-1:0] d1x, d1y, fxw, fyw, kxw, kyw;
    res_t                 res;

    always_comb begin
        sd = side_reg[QB-1];
        for (int i = 0; i < 6; i++) begin
            qs[i] = $signed(PW'(sd.ovf[i] ? {QB{1'b1}} : quo[i]));
            if (sd.neg[i]) begin
                qs[i] = -qs[i];
            end
        end

        d1x = sd.lo1 ? sd.dl1x : (sd.hi1 ? -sd.dl1x : (sd.z1 ? '0 : -qs[0]));
        d1y = sd.lo1 ? sd.dl1y : (sd.hi1 ? -sd.dl1y : (sd.z1 ? '0 : -qs[1]));
        fxw = sat(sx(sd.ux) + d1x, OB);
        fyw = sat(sx(sd.uy) + d1y, OB);

        if (sd.lo3 || sd.hi3) begin
            // outside the dead zone: damped flow plus/minus ltd*b
            kxw = sat(qs[4] + (sd.lo3 ? -sd.dl3x : sd.dl3x), OB);
            kyw = sat(qs[5] + (sd.lo3 ? -sd.dl3y : sd.dl3y), OB);
        end else begin
            kxw = sat(sx(sd.ux) + (sd.z3 ? '0 : qs[2]), OB);
            kyw = sat(sx(sd.uy) + (sd.z3 ? '0 : qs[3]), OB);
        end

        res.fx   = 32'(fxw);
        res.fy   = 32'(fyw);
        res.kx   = 32'(kxw);
        res.ky   = 32'(kyw);
        res.last = sd.last;
        if (sd.chi < cfg.occ_thr) begin
            res.vx = res.fx;
            res.vy = res.fy;
        end else begin
            res.vx = res.kx;
            res.vy = res.ky;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg <= res;
        end
    end

    // ---------------------------------------------------------------
    // valid bits, output register and skid slot
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vpipe_reg  <= '0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (adv) begin
                vpipe_reg <= {vpipe_reg[NST-2:0], take};
            end
            if (!skid_v_reg) begin
                if (!out_v_reg || m_tready) begin
                    out_v_reg <= vpipe_reg[NST-1];
                end else if (vpipe_reg[NST-1]) begin
                    skid_v_reg <= 1'b1;
                end
            end else if (m_tready) begin
                skid_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_v_reg) begin
            if (!out_v_reg || m_tready) begin
                out_reg <= p_reg;
            end else begin
                skid_reg <= p_reg;
            end
        end else if (m_tready) begin
            out_reg <= skid_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_reg.ky, out_reg.kx, out_reg.fy, out_reg.fx,
                       out_reg.vy, out_reg.vx};
    assign m_tlast  = out_reg.last;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid slot holds a transaction while output is empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_v_reg) |-> $past(out_v_reg && !m_tready))
        else $error("skid slot filled without an output stall");

    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input accepted before derived gains were refreshed");

endmodule
